// ===== sv/scfl_pkg.sv =====
// Shared constants, types and helper functions of the size-class free-list allocator.
package scfl_pkg;

    localparam int SMALL_BLOCK_BYTES = 128;
    localparam int SMALL_BLOCK_COUNT = 128;
    localparam int NUM_CLASSES       = 5;

    localparam int LOG2_BYTES  = $clog2(SMALL_BLOCK_BYTES);
    localparam int LOG2_REGION = $clog2(SMALL_BLOCK_BYTES * SMALL_BLOCK_COUNT);
    localparam int CLS_W       = $clog2(NUM_CLASSES);

    function automatic int total_blocks();
        int s;
        s = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            s += SMALL_BLOCK_COUNT >> k;
        end
        return s;
    endfunction

    localparam int NUM_BLOCKS = total_blocks();
    localparam int BLK_W      = $clog2(NUM_BLOCKS);

    localparam int PADDR_W         = 2;
    localparam int REG_ADDRESS_BASE = 0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [CLS_W-1:0] t_cls;

    typedef struct packed {
        logic rd_en;
        t_blk rd_addr;
        logic wr_en;
        t_blk wr_addr;
        t_blk wr_data;
    } t_link_req;

    typedef struct packed {
        logic rd_en;
        t_blk rd_addr;
        logic wr_en;
        t_blk wr_addr;
        logic wr_data;
    } t_flag_req;

    function automatic logic [LOG2_REGION:0] cls_count(input t_cls c);
        return (LOG2_REGION + 1)'(SMALL_BLOCK_COUNT >> c);
    endfunction

    function automatic t_blk cls_start(input t_cls c);
        int s;
        s = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (k < int'(c)) begin
                s += SMALL_BLOCK_COUNT >> k;
            end
        end
        return BLK_W'(s);
    endfunction

    function automatic t_blk cls_last(input t_cls c);
        int n;
        n = SMALL_BLOCK_COUNT >> c;
        if (n > 0) begin
            return cls_start(c) + BLK_W'(n - 1);
        end
        return cls_start(c);
    endfunction

endpackage

// ===== sv/scfl_link_mem.sv =====
// Next-link memory: one successor index per block, with written marks for reset values.
module scfl_link_mem import scfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_link_req i_req,
    output t_blk      o_rd_data
);

    t_blk                  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_written;
    t_blk                  r_rd_data;
    t_blk                  r_rd_addr;
    logic                  r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_written[i_req.rd_addr];
            end
        end
    end

    // An entry never written still links to the block with the next index.
    assign o_rd_data = r_rd_hit ? r_rd_data : r_rd_addr + 1'b1;

endmodule

// ===== sv/scfl_flag_mem.sv =====
// Allocated-flag memory: one bit per block, reading as free until first written.
module scfl_flag_mem import scfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_flag_req i_req,
    output logic      o_rd_data
);

    logic                  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_written;
    logic                  r_rd_data;
    logic                  r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit & r_rd_data;

endmodule

// ===== sv/scfl_ctrl.sv =====
// Request decode, list head and tail registers, memory sequencing and result register.
module scfl_ctrl import scfl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_address_base,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_func,
    input  logic [15:0] i_request_size,
    input  logic [31:0] i_block_address,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic        o_ok,
    output logic [31:0] o_granted_address,
    output logic [1:0]  o_status,
    output t_link_req   o_link_req,
    input  t_blk        i_link_rd,
    output t_flag_req   o_flag_req,
    input  logic        i_flag_rd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                   r_state;
    logic                   r_func;
    logic [1:0]             r_status;
    t_cls                   r_cls;
    t_blk                   r_blk;
    t_blk                   r_head [NUM_CLASSES];
    t_blk                   r_tail [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_valid;
    logic                   r_out_vld;
    logic                   r_ok;
    logic [31:0]            r_addr;
    logic [1:0]             r_st;

    logic                    n_state;
    logic                    s_acc;
    logic [CLS_W:0]          a_first;
    logic                    a_fit;
    logic                    a_found;
    t_cls                    a_cls;
    logic [31:0]             f_off;
    logic [31-LOG2_REGION:0] f_hi;
    t_cls                    f_cls;
    logic [LOG2_REGION-1:0]  f_idx;
    logic                    f_ok;
    t_blk                    f_blk;
    logic                    commit;
    logic                    e_alloc_ok;
    logic                    e_free_ok;
    logic [1:0]              e_status;
    logic [31:0]             e_addr;

    always_comb begin
        a_first = (CLS_W + 1)'(NUM_CLASSES);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ({16'b0, i_request_size} <= 32'(SMALL_BLOCK_BYTES << k)) begin
                a_first = (CLS_W + 1)'(k);
            end
        end
        a_fit   = (i_request_size != 16'd0) && (a_first < (CLS_W + 1)'(NUM_CLASSES));
        a_found = 1'b0;
        a_cls   = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (r_valid[k] && ((CLS_W + 1)'(k) >= a_first)) begin
                a_found = 1'b1;
                a_cls   = CLS_W'(k);
            end
        end
    end

    always_comb begin
        f_off = i_block_address - i_address_base;
        f_hi  = f_off[31:LOG2_REGION];
        f_cls = f_hi[CLS_W-1:0];
        f_idx = f_off[LOG2_REGION-1:0] >> (LOG2_BYTES + int'(f_cls));
        f_ok  = (f_hi < (32 - LOG2_REGION)'(NUM_CLASSES))
             && ({1'b0, f_idx} < cls_count(f_cls));
        f_blk = cls_start(f_cls) + BLK_W'(f_idx);
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && (r_state == S_IDLE);
    assign commit     = (r_state == S_EXEC) && (!r_out_vld || i_m_tready);

    assign e_alloc_ok = (r_func == FUNC_ALLOC) && (r_status == ST_OK);
    assign e_free_ok  = (r_func == FUNC_FREE) && (r_status == ST_OK) && i_flag_rd;

    always_comb begin
        e_status = r_status;
        if ((r_func == FUNC_FREE) && (r_status == ST_OK) && !i_flag_rd) begin
            e_status = ST_NOT_ALLOC;
        end
        e_addr = '0;
        if (e_alloc_ok) begin
            e_addr = i_address_base + (32'(r_cls) << LOG2_REGION)
                   + (32'(r_blk - cls_start(r_cls)) << (LOG2_BYTES + int'(r_cls)));
        end
    end

    always_comb begin
        o_link_req.rd_en   = s_acc && (i_func == FUNC_ALLOC);
        o_link_req.rd_addr = r_head[a_cls];
        o_link_req.wr_en   = commit && e_free_ok && r_valid[r_cls];
        o_link_req.wr_addr = r_tail[r_cls];
        o_link_req.wr_data = r_blk;
        o_flag_req.rd_en   = s_acc && (i_func == FUNC_FREE) && f_ok;
        o_flag_req.rd_addr = f_blk;
        o_flag_req.wr_en   = commit && (e_alloc_ok || e_free_ok);
        o_flag_req.wr_addr = r_blk;
        o_flag_req.wr_data = e_alloc_ok;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_head[k]  <= cls_start(CLS_W'(k));
                r_tail[k]  <= cls_last(CLS_W'(k));
                r_valid[k] <= ((SMALL_BLOCK_COUNT >> k) > 0);
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (commit && e_alloc_ok) begin
                if (r_blk == r_tail[r_cls]) begin
                    r_valid[r_cls] <= 1'b0;
                end else begin
                    r_head[r_cls] <= i_link_rd;
                end
            end
            if (commit && e_free_ok) begin
                if (!r_valid[r_cls]) begin
                    r_head[r_cls]  <= r_blk;
                    r_valid[r_cls] <= 1'b1;
                end
                r_tail[r_cls] <= r_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_func <= i_func;
            if (i_func == FUNC_ALLOC) begin
                r_cls    <= a_cls;
                r_blk    <= r_head[a_cls];
                r_status <= (a_fit && a_found) ? ST_OK : ST_NO_SPACE;
            end else begin
                r_cls    <= f_cls;
                r_blk    <= f_blk;
                r_status <= f_ok ? ST_OK : ST_BAD_ADDR;
            end
        end
        if (commit) begin
            r_ok   <= (e_status == ST_OK);
            r_addr <= e_addr;
            r_st   <= e_status;
        end
    end

    assign o_m_tvalid        = r_out_vld;
    assign o_ok              = r_ok;
    assign o_granted_address = r_addr;
    assign o_status          = r_st;

endmodule

// ===== sv/size_class_free_list_allocator_core.sv =====
// Top level of the size-class free-list allocator: register port and block instances.
//
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   tuser: func; tdata: request_size, block_address
// m         out        o_m_tvalid / i_m_tready   tdata: ok, granted_address, status
// apb       in         psel, penable / pready    address_base at byte address 0
//
// Every request runs as a decode step with a read of the link or flag memory, then an
// update step with the list update, memory write-back and result register load.
// A new request is accepted in the cycle after the result is registered.
// While the result register is full and not taken, the update step waits.
// Reset is synchronous; lists come up in their initial order at once, with no sweep.
module size_class_free_list_allocator_core import scfl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [47:0]        i_s_tdata,   // [15:0] request_size, [47:16] block_address
    input  logic [0:0]         i_s_tuser,   // [0] func
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [39:0]        o_m_tdata,   // [0] ok, [32:1] granted_address, [34:33] status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] r_address_base;
    t_link_req   link_req;
    t_blk        link_rd;
    t_flag_req   flag_req;
    logic        flag_rd;
    logic        m_ok;
    logic [31:0] m_addr;
    logic [1:0]  m_status;

    assign pready = 1'b1;
    assign prdata = (paddr == PADDR_W'(4 * REG_ADDRESS_BASE)) ? r_address_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_base <= 32'd0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == PADDR_W'(4 * REG_ADDRESS_BASE))) begin
            r_address_base <= pwdata;
        end
    end

    scfl_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_address_base    (r_address_base),
        .i_s_tvalid        (i_s_tvalid),
        .o_s_tready        (o_s_tready),
        .i_func            (i_s_tuser[0]),
        .i_request_size    (i_s_tdata[15:0]),
        .i_block_address   (i_s_tdata[47:16]),
        .o_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .o_ok              (m_ok),
        .o_granted_address (m_addr),
        .o_status          (m_status),
        .o_link_req        (link_req),
        .i_link_rd         (link_rd),
        .o_flag_req        (flag_req),
        .i_flag_rd         (flag_rd)
    );

    scfl_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (link_req),
        .o_rd_data (link_rd)
    );

    scfl_flag_mem u_flag_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (flag_req),
        .o_rd_data (flag_rd)
    );

    assign o_m_tdata = {5'd0, m_status, m_addr, m_ok};

endmodule

// ===== sv/scfl_checker.sv =====
// Port-level checker for the allocator core and its bind statement.
module scfl_checker import scfl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[34:33] == ST_OK)))
        else $error("ok flag disagrees with status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[32:1] == 32'd0))
        else $error("failed request carries an address");

endmodule

bind size_class_free_list_allocator_core scfl_checker u_scfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the size-class free-list allocator core.
`timescale 1ns / 100ps

module testbench;
    import scfl_pkg::*;

    localparam int REGION_BYTES = SMALL_BLOCK_BYTES * SMALL_BLOCK_COUNT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_PROBES   = 26;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
        logic [1:0]  status;
    } t_grant;

    typedef struct packed {
        logic        fn;
        logic [15:0] size;
        logic [31:0] addr;
        logic        typed;
        t_grant      want;
    } t_probe;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [47:0]        i_s_tdata  = '0;   // [15:0] request_size, [47:16] block_address
    logic [0:0]         i_s_tuser  = '0;   // [0] func
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [39:0]        o_m_tdata;         // [0] ok, [32:1] granted_address, [34:33] status
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic [31:0]        prdata;
    logic               pready;

    size_class_free_list_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bit          pool_free   [NUM_BLOCKS];
    bit          has_succ    [NUM_BLOCKS];
    int          succ        [NUM_BLOCKS];
    bit          class_avail [NUM_CLASSES];
    int          class_head  [NUM_CLASSES];
    int          class_tail  [NUM_CLASSES];
    logic [31:0] pool_base;

    t_grant pending_grants [$];
    t_grant seen_grant;
    t_grant want_grant;
    int     mismatch_count  = 0;
    int     cycle_count     = 0;
    int     feed_idle_pct   = 0;
    int     drain_stall_pct = 0;
    int     alloc_bias      = 50;

    t_probe opening_probes [NUM_PROBES] = '{
        {FUNC_ALLOC, 16'd1,     32'h0,       1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd128,   32'h0,       1'b1, {1'b1, 32'h80,     ST_OK}},
        {FUNC_ALLOC, 16'd129,   32'h0,       1'b1, {1'b1, 32'h4000,   ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b1, {1'b1, 32'h1_0000, ST_OK}},
        {FUNC_ALLOC, 16'd0,     32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,      ST_NO_SPACE}},
        {FUNC_ALLOC, 16'd2049,  32'h0,       1'b1, {1'b0, 32'h0,      ST_NO_SPACE}},
        {FUNC_ALLOC, 16'hFFFF,  32'h0,       1'b1, {1'b0, 32'h0,      ST_NO_SPACE}},
        {FUNC_FREE,  16'hFFFF,  32'h0,       1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_FREE,  16'h0,     32'h0,       1'b1, {1'b0, 32'h0,      ST_NOT_ALLOC}},
        {FUNC_FREE,  16'h0,     32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,      ST_BAD_ADDR}},
        {FUNC_FREE,  16'h0,     32'h1_4000,  1'b1, {1'b0, 32'h0,      ST_BAD_ADDR}},
        {FUNC_FREE,  16'h0,     32'h1_07FF,  1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_FREE,  16'h0,     32'h404D,    1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_FREE,  16'h0,     32'hC8,      1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd1,     32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd1025,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd1025,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2000,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b1, {1'b0, 32'h0,      ST_NO_SPACE}},
        {FUNC_FREE,  16'h0,     32'h1_1800,  1'b1, {1'b1, 32'h0,      ST_OK}},
        {FUNC_ALLOC, 16'd2048,  32'h0,       1'b0, {1'b0, 32'h0,      ST_OK}}
    };

    function automatic int class_first(input int c);
        int s;
        s = 0;
        for (int k = 0; k < c; k++) begin
            s += SMALL_BLOCK_COUNT >> k;
        end
        return s;
    endfunction

    function automatic int class_of_block(input int b);
        int c;
        c = 0;
        while (c < NUM_CLASSES - 1 && b >= class_first(c + 1)) begin
            c++;
        end
        return c;
    endfunction

    function automatic void reset_pool();
        int s;
        int n;
        pool_base = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            s = class_first(c);
            n = SMALL_BLOCK_COUNT >> c;
            for (int i = 0; i < n; i++) begin
                pool_free[s + i] = 1'b1;
                has_succ[s + i]  = (i + 1 < n);
                succ[s + i]      = (i + 1 < n) ? s + i + 1 : 0;
            end
            class_avail[c] = (n > 0);
            class_head[c]  = s;
            class_tail[c]  = (n > 0) ? s + n - 1 : s;
        end
    endfunction

    function automatic t_grant predict_grant(input logic fn, input logic [15:0] size,
                                             input logic [31:0] addr);
        t_grant      g;
        int          first;
        int          b;
        int          c;
        int          idx;
        logic [31:0] off;
        g     = '{ok: 1'b0, addr: 32'h0, status: ST_NO_SPACE};
        first = NUM_CLASSES;
        if (fn == FUNC_ALLOC) begin
            for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
                if (int'(size) <= (SMALL_BLOCK_BYTES << k)) begin
                    first = k;
                end
            end
            if (size == 16'd0) begin
                first = NUM_CLASSES;
            end
            for (int k = first; k < NUM_CLASSES; k++) begin
                if (class_avail[k]) begin
                    b = class_head[k];
                    pool_free[b] = 1'b0;
                    if (has_succ[b]) begin
                        class_head[k] = succ[b];
                    end else begin
                        class_avail[k] = 1'b0;
                    end
                    g.ok     = 1'b1;
                    g.addr   = pool_base + 32'(k * REGION_BYTES)
                             + 32'((b - class_first(k)) * (SMALL_BLOCK_BYTES << k));
                    g.status = ST_OK;
                    return g;
                end
            end
            return g;
        end
        off = addr - pool_base;
        if (off >= 32'(NUM_CLASSES * REGION_BYTES)) begin
            g.status = ST_BAD_ADDR;
            return g;
        end
        c   = int'(off) / REGION_BYTES;
        idx = (int'(off) % REGION_BYTES) / (SMALL_BLOCK_BYTES << c);
        if (idx >= (SMALL_BLOCK_COUNT >> c)) begin
            g.status = ST_BAD_ADDR;
            return g;
        end
        b = class_first(c) + idx;
        if (pool_free[b]) begin
            g.status = ST_NOT_ALLOC;
            return g;
        end
        if (!class_avail[c]) begin
            class_head[c]  = b;
            class_avail[c] = 1'b1;
        end else begin
            has_succ[class_tail[c]] = 1'b1;
            succ[class_tail[c]]     = b;
        end
        class_tail[c] = b;
        pool_free[b]  = 1'b1;
        has_succ[b]   = 1'b0;
        succ[b]       = 0;
        g.ok     = 1'b1;
        g.status = ST_OK;
        return g;
    endfunction

    // Picks a random block that is free or allocated as asked, or -1 if there is none.
    function automatic int pick_block(input bit want_free);
        int found [$];
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (pool_free[b] == want_free) begin
                found.push_back(b);
            end
        end
        if (found.size() == 0) begin
            return -1;
        end
        return found[$urandom_range(found.size() - 1)];
    endfunction

    task automatic issue_request(input logic fn, input logic [15:0] size,
                                 input logic [31:0] addr, input logic typed,
                                 input t_grant want);
        t_grant guess;
        while ($urandom_range(99) < feed_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        guess = predict_grant(fn, size, addr);
        pending_grants.push_back(typed ? want : guess);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= fn;
        i_s_tdata  <= {addr, size};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        logic [15:0] size;
        logic [31:0] addr;
        int          cls;
        int          blk;
        size = 16'($urandom);
        addr = $urandom;
        blk  = -1;
        if ($urandom_range(99) < alloc_bias) begin
            case ($urandom_range(9))
                0: begin
                end
                1: begin
                    size = 16'(SMALL_BLOCK_BYTES << $urandom_range(NUM_CLASSES - 1))
                         + 16'($urandom_range(1));
                end
                default: begin
                    cls  = $urandom_range(NUM_CLASSES - 1);
                    size = 16'($urandom_range(SMALL_BLOCK_BYTES << cls, 1));
                end
            endcase
            issue_request(FUNC_ALLOC, size, addr, 1'b0, '0);
        end else begin
            case ($urandom_range(9))
                0: begin
                end
                1: begin
                    addr = pool_base + 32'($urandom_range((NUM_CLASSES + 1) * REGION_BYTES));
                end
                2: begin
                    blk = pick_block(1'b1);
                end
                default: begin
                    blk = pick_block(1'b0);
                end
            endcase
            if (blk >= 0) begin
                cls  = class_of_block(blk);
                addr = pool_base + 32'(cls * REGION_BYTES)
                     + 32'((blk - class_first(cls)) * (SMALL_BLOCK_BYTES << cls))
                     + 32'($urandom_range((SMALL_BLOCK_BYTES << cls) - 1));
            end
            issue_request(FUNC_FREE, size, addr, 1'b0, '0);
        end
    endtask

    task automatic write_pool_base(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_ADDRESS_BASE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        pool_base  = value;
    endtask

    task automatic wait_drained();
        while (pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= drain_stall_pct);
            if (o_m_tvalid && i_m_tready) begin
                seen_grant.ok     = o_m_tdata[0];
                seen_grant.addr   = o_m_tdata[32:1];
                seen_grant.status = o_m_tdata[34:33];
                if (pending_grants.size() == 0) begin
                    $display("%0t: unexpected result ok=%0b addr=%h status=%0d", $time,
                             seen_grant.ok, seen_grant.addr, seen_grant.status);
                    mismatch_count++;
                end else begin
                    want_grant = pending_grants.pop_front();
                    if (seen_grant.ok !== want_grant.ok) begin
                        $display("%0t: ok expected %0b, got %0b", $time,
                                 want_grant.ok, seen_grant.ok);
                        mismatch_count++;
                    end
                    if (seen_grant.addr !== want_grant.addr) begin
                        $display("%0t: granted_address expected %h, got %h", $time,
                                 want_grant.addr, seen_grant.addr);
                        mismatch_count++;
                    end
                    if (seen_grant.status !== want_grant.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want_grant.status, seen_grant.status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] phase_base [NUM_PHASES];
        phase_base = '{32'hFFFF_FFFF, $urandom, 32'h0, 32'hFFFE_C000, $urandom, 32'h8000_0000};
        reset_pool();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_pool_base(32'h0);
        for (int n = 0; n < NUM_PROBES; n++) begin
            issue_request(opening_probes[n].fn, opening_probes[n].size, opening_probes[n].addr,
                          opening_probes[n].typed, opening_probes[n].want);
        end
        i_s_tvalid <= 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            write_pool_base(phase_base[phase]);
            case (phase % 4)
                0: begin
                    feed_idle_pct = 0;
                    drain_stall_pct = 0;
                end
                1: begin
                    feed_idle_pct = 66;
                    drain_stall_pct = 0;
                end
                2: begin
                    feed_idle_pct = 0;
                    drain_stall_pct = 66;
                end
                default: begin
                    feed_idle_pct = 38;
                    drain_stall_pct = 38;
                end
            endcase
            alloc_bias = (phase % 2 == 0) ? 70 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
            end
            i_s_tvalid <= 1'b0;
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
